[sv/lcs_pkg.sv]
// lcs_pkg: shared widths, request codes and limits for the letter composition scorer
// used by every module of the block, no dependencies
`default_nettype none

package lcs_pkg;

    localparam int REQ_W       = 2;
    localparam int LETTER_W    = 4;
    localparam int WEIGHT_W    = 16;
    localparam int SCORE_W     = 20;
    localparam int CNT_W       = 8;
    localparam int FRAC_W      = 16;
    localparam int TERM_W      = WEIGHT_W + 1;
    localparam int PROD_W      = 2 * TERM_W;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    localparam int DEF_ALPHA_SIZE = 16;

    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_A      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_B      = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SCORE  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hff;

    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 20'sh7ffff;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 20'sh80000;

endpackage

`default_nettype wire

[sv/lcs_div.sv]
// lcs_div: restoring divider, one quotient bit per cycle, gives floor(num * 2^16 / den)
// for num < den; depends on lcs_pkg
`default_nettype none

module lcs_div
    import lcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CNT_W-1:0]  i_num,
    input  wire logic [CNT_W-1:0]  i_den,
    output logic                   o_done,
    output logic [FRAC_W-1:0]      o_quo
);

    localparam int STEP_W = $clog2(FRAC_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_quo;

    logic [CNT_W:0]    n_shift;
    logic              n_fits;
    logic [CNT_W:0]    n_diff;

    always_comb begin
        n_shift = {r_rem, 1'b0};
        n_fits  = (n_shift >= {1'b0, r_den});
        n_diff  = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(FRAC_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // remainder stays below den, so it fits the counter width
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_fits ? n_diff[CNT_W-1:0] : n_shift[CNT_W-1:0];
            r_quo <= {r_quo[FRAC_W-2:0], n_fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

[sv/letter_composition_similarity.sv]
// letter_composition_similarity: top level, histograms, weight table and score sequencer
// steps: a weight load ends in idle, a letter passes bump, a score reads and evaluates
// each letter (skip if both counts are zero, accumulate if equal, else divide, multiply, round,
// accumulate), then waits in done for a free output; one item at a time, taken in idle
// reset: synchronous active low; clears histograms and weights through valid bits
// depends on lcs_pkg and lcs_div
`default_nettype none

module letter_composition_similarity
    import lcs_pkg::*;
#(
    parameter int ALPHA_SIZE = DEF_ALPHA_SIZE
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [3:0] letter, [19:4] weight_value, [23:20] zero
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [REQ_W-1:0]     s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [19:0] score, [23:20] zero
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    localparam int IDX_W = $clog2(ALPHA_SIZE);
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_BUMP = 4'd1;
    localparam logic [ST_W-1:0] S_READ = 4'd2;
    localparam logic [ST_W-1:0] S_EVAL = 4'd3;
    localparam logic [ST_W-1:0] S_DIV  = 4'd4;
    localparam logic [ST_W-1:0] S_MUL  = 4'd5;
    localparam logic [ST_W-1:0] S_RND  = 4'd6;
    localparam logic [ST_W-1:0] S_ACC  = 4'd7;
    localparam logic [ST_W-1:0] S_DONE = 4'd8;

    logic [ST_W-1:0]             r_state;
    logic [ALPHA_SIZE-1:0]       r_va;
    logic [ALPHA_SIZE-1:0]       r_vb;
    logic [ALPHA_SIZE-1:0]       r_vw;
    logic [CNT_W-1:0]            r_mem_a [ALPHA_SIZE];
    logic [CNT_W-1:0]            r_mem_b [ALPHA_SIZE];
    logic [WEIGHT_W-1:0]         r_mem_w [ALPHA_SIZE];
    logic [CNT_W-1:0]            r_rd_a;
    logic [CNT_W-1:0]            r_rd_b;
    logic [WEIGHT_W-1:0]         r_rd_w;
    logic [IDX_W-1:0]            r_idx;
    logic                        r_side_b;
    logic [IDX_W-1:0]            r_k;
    logic signed [TERM_W-1:0]    r_term;
    logic signed [TERM_W-1:0]    r_w;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SCORE_W-1:0]   r_sum;
    logic                        r_ovalid;
    logic [SCORE_W-1:0]          r_score;

    logic [REQ_W-1:0]            req_type;
    logic [LETTER_W-1:0]         letter;
    logic [WEIGHT_W-1:0]         weight_value;
    logic                        accept;
    logic                        in_range;
    logic [IDX_W-1:0]            in_idx;
    logic [ALPHA_SIZE-1:0]       n_vb_set;

    logic [CNT_W-1:0]            bump_cur;
    logic [CNT_W-1:0]            na;
    logic [CNT_W-1:0]            nb;
    logic [CNT_W-1:0]            lo;
    logic [CNT_W-1:0]            hi;
    logic                        walk_last;
    logic                        out_free;
    logic signed [PROD_W-1:0]    n_round;
    logic signed [SCORE_W:0]     n_acc;
    logic signed [SCORE_W-1:0]   n_sum;

    logic                        div_start;
    logic                        div_done;
    logic [FRAC_W-1:0]           div_quo;

    assign req_type     = s_axis_tuser;
    assign letter       = s_axis_tdata[LETTER_W-1:0];
    assign weight_value = s_axis_tdata[LETTER_W +: WEIGHT_W];
    assign accept       = s_axis_tvalid && s_axis_tready;
    assign in_range     = (32'(letter) < 32'(ALPHA_SIZE));
    assign in_idx       = IDX_W'(letter);
    assign s_axis_tready = (r_state == S_IDLE);
    assign n_vb_set     = '0;

    assign bump_cur  = r_side_b ? (r_vb[r_idx] ? r_rd_b : '0)
                                : (r_va[r_idx] ? r_rd_a : '0);
    assign na        = r_va[r_k] ? r_rd_a : '0;
    assign nb        = r_vb[r_k] ? r_rd_b : '0;
    assign lo        = (na < nb) ? na : nb;
    assign hi        = (na < nb) ? nb : na;
    assign walk_last = (r_k == IDX_W'(ALPHA_SIZE - 1));
    assign out_free  = !r_ovalid || m_axis_tready;
    assign div_start = (r_state == S_EVAL) && (hi != '0) && (lo != hi);

    // round half up, then arithmetic shift down to Q8.8
    assign n_round = r_prod + PROD_W'(32768);

    always_comb begin
        n_acc = {r_sum[SCORE_W-1], r_sum} + (SCORE_W + 1)'(r_term);
        if (n_acc[SCORE_W] != n_acc[SCORE_W-1]) begin
            n_sum = n_acc[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        end else begin
            n_sum = n_acc[SCORE_W-1:0];
        end
    end

    lcs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (lo),
        .i_den   (hi),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // memories: one write port each; registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_rd_a <= r_mem_a[in_idx];
            r_rd_b <= r_mem_b[in_idx];
        end else begin
            r_rd_a <= r_mem_a[r_k];
            r_rd_b <= r_mem_b[r_k];
        end
        r_rd_w <= r_mem_w[r_k];
        if (accept && req_type == REQ_LOAD && in_range) begin
            r_mem_w[in_idx] <= weight_value;
        end
        if (r_state == S_BUMP && bump_cur != CNT_MAX) begin
            if (r_side_b) begin
                r_mem_b[r_idx] <= bump_cur + 1'b1;
            end else begin
                r_mem_a[r_idx] <= bump_cur + 1'b1;
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_va     <= '0;
            r_vb     <= '0;
            r_vw     <= '0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            // the done state loads the next word itself
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (req_type) inside
                            REQ_LOAD: begin
                                if (in_range) begin
                                    r_vw[in_idx] <= 1'b1;
                                end
                            end
                            REQ_A, REQ_B: begin
                                if (in_range) begin
                                    r_state <= S_BUMP;
                                end
                            end
                            default: begin
                                r_k     <= '0;
                                r_state <= S_READ;
                            end
                        endcase
                    end
                end
                S_BUMP: begin
                    if (bump_cur != CNT_MAX) begin
                        if (r_side_b) begin
                            r_vb[r_idx] <= 1'b1;
                        end else begin
                            r_va[r_idx] <= 1'b1;
                        end
                    end
                    r_state <= S_IDLE;
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (hi == '0) begin
                        if (walk_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_READ;
                        end
                    end else if (lo == hi) begin
                        r_state <= S_ACC;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (walk_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_va     <= n_vb_set;
                        r_vb     <= n_vb_set;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx    <= in_idx;
            r_side_b <= (req_type == REQ_B);
            r_sum    <= '0;
        end
        if (r_state == S_EVAL) begin
            r_w    <= TERM_W'($signed(r_vw[r_k] ? r_rd_w : '0));
            r_term <= TERM_W'($signed(r_vw[r_k] ? r_rd_w : '0));
        end
        if (r_state == S_MUL) begin
            r_prod <= r_w * $signed({1'b0, div_quo});
        end
        if (r_state == S_RND) begin
            r_term <= n_round[FRAC_W +: TERM_W];
        end
        if (r_state == S_ACC) begin
            r_sum <= n_sum;
        end
        if (r_state == S_DONE && out_free) begin
            r_score <= r_sum;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = M_TDATA_W'(r_score);

endmodule

`default_nettype wire

[sv/lcs_checker.sv]
// lcs_checker: port-level assertions for letter_composition_similarity, bound to the top
// depends on lcs_pkg
`default_nettype none

module lcs_checker
    import lcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [REQ_W-1:0]     s_axis_tuser,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata
);

    // no word leaves right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output word valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed while stalled");

    // score is sign-free above bit 19: padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:SCORE_W] == '0)
        else $error("output padding not zero");

    // in-range letter words and score words keep the block busy for the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_LOAD
            && (s_axis_tuser == REQ_SCORE
                || 32'(s_axis_tdata[LETTER_W-1:0]) < 32'(DEF_ALPHA_SIZE))
        |=> !s_axis_tready)
        else $error("accepted a word while a letter or score was in work");

    // a new score only follows a score request
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output word without a score walk");

endmodule

bind letter_composition_similarity lcs_checker u_lcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
